@@ rtl/dapa_pkg.sv @@
// Shared widths, constants, angle table and types of the direction angle pipeline.
package dapa_pkg;

  // Magnitudes are scaled until below 2^17, then taken to Q8
  localparam int MAG_W      = 17;
  localparam int Q_FRAC     = 8;
  localparam int Q8_W       = MAG_W + Q_FRAC;
  // Square root: 26 result bits from a 52-bit radicand
  localparam int SQ_BITS    = 26;
  localparam int SQ_W       = 2 * SQ_BITS;
  // CORDIC operands (covers Q8 magnitudes and rho)
  localparam int OPD_W      = SQ_BITS;
  localparam int PRESHIFT   = 20;
  localparam int CR_W       = OPD_W + PRESHIFT + 4;
  localparam int Z_W        = 26;
  localparam int ANG_W      = 23;
  localparam int AZ_W       = 25;
  localparam int FRAC_DEG   = 16;
  localparam int AZ_DEG_W   = 9;
  localparam int PO_DEG_W   = 8;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [Z_W-1:0] DEG90_Z    = Z_W'(5898240);
  localparam logic [ANG_W-1:0]      DEG90_A    = ANG_W'(5898240);
  localparam logic [AZ_W-1:0]       DEG180_Q16 = AZ_W'(11796480);
  localparam logic [AZ_W-1:0]       DEG360_Q16 = AZ_W'(23592960);
  localparam logic [AZ_W-1:0]       ROUND_HALF = AZ_W'(32768);

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
    Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
    Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
    Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
    Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
    Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
    Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
  };

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic zero;
  } flags_t;

  typedef struct packed {
    logic [Q8_W-1:0] mx;
    logic [Q8_W-1:0] my;
    logic [Q8_W-1:0] mz;
    flags_t          fl;
  } mags_t;

  typedef struct packed {
    logic [AZ_DEG_W-1:0] azimuth_deg;
    logic [PO_DEG_W-1:0] polar_deg;
    logic                zero_length;
  } res_t;

endpackage

@@ rtl/dapa_if.sv @@
// Valid/ready channel interfaces for point pairs and direction angles.
interface dapa_in_if import dapa_pkg::*; #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] start_z;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface dapa_out_if import dapa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [AZ_DEG_W-1:0] azimuth_deg;
  logic [PO_DEG_W-1:0] polar_deg;
  logic                zero_length;

  modport source (output valid, azimuth_deg, polar_deg, zero_length, input ready);
  modport sink   (input valid, azimuth_deg, polar_deg, zero_length, output ready);
endinterface

@@ rtl/dapa_front.sv @@
// Front end: difference vector, magnitudes, range scaling and Q8 conversion.
module dapa_front import dapa_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] start_z,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] end_z,
  output logic                          out_valid,
  output mags_t                         out_mags
);

  localparam int D_W   = COORD_WIDTH + 1;
  localparam int EXT_W = (D_W > MAG_W) ? D_W : MAG_W;
  localparam int SH_W  = $clog2(EXT_W + 1);

  logic           v1, v2, v3, v4;
  logic [D_W-1:0] dx, dy, dz;
  logic [D_W-1:0] mx2, my2, mz2;
  logic [D_W-1:0] mx3, my3, mz3;
  flags_t         fl2, fl3;
  logic [SH_W-1:0] sh3;
  logic [D_W-1:0]  or_mag;
  logic [SH_W-1:0] bit_len;
  logic [SH_W-1:0] sh_next;
  logic [EXT_W-1:0] mx_sh, my_sh, mz_sh;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: form the difference vector
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
      dy <= {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
      dz <= {end_z[COORD_WIDTH-1], end_z} - {start_z[COORD_WIDTH-1], start_z};
    end
  end

  // Stage 2: take magnitudes and signs, flag the zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      mx2       <= dx[D_W-1] ? (~dx + 1'b1) : dx;
      my2       <= dy[D_W-1] ? (~dy + 1'b1) : dy;
      mz2       <= dz[D_W-1] ? (~dz + 1'b1) : dz;
      fl2.neg_x <= dx[D_W-1];
      fl2.neg_y <= dy[D_W-1];
      fl2.neg_z <= dz[D_W-1];
      fl2.zero  <= (dx == '0) && (dy == '0) && (dz == '0);
    end
  end

  // Find the common right shift that brings the largest magnitude below 2^17
  always_comb begin
    or_mag  = mx2 | my2 | mz2;
    bit_len = '0;
    for (int i = 0; i < D_W; i++) begin
      if (or_mag[i]) bit_len = SH_W'(i + 1);
    end
    sh_next = (bit_len > SH_W'(MAG_W)) ? (bit_len - SH_W'(MAG_W)) : '0;
  end

  // Stage 3: hold magnitudes and the shift
  always_ff @(posedge clk) begin
    if (en) begin
      mx3 <= mx2;
      my3 <= my2;
      mz3 <= mz2;
      fl3 <= fl2;
      sh3 <= sh_next;
    end
  end

  assign mx_sh = EXT_W'(mx3) >> sh3;
  assign my_sh = EXT_W'(my3) >> sh3;
  assign mz_sh = EXT_W'(mz3) >> sh3;

  // Stage 4: apply the shift and move to Q8
  always_ff @(posedge clk) begin
    if (en) begin
      out_mags.mx <= {mx_sh[MAG_W-1:0], {Q_FRAC{1'b0}}};
      out_mags.my <= {my_sh[MAG_W-1:0], {Q_FRAC{1'b0}}};
      out_mags.mz <= {mz_sh[MAG_W-1:0], {Q_FRAC{1'b0}}};
      out_mags.fl <= fl3;
    end
  end

  assign out_valid = v4;

endmodule

@@ rtl/dapa_sqrt.sv @@
// Pipelined integer square root of mx^2 + my^2, one result bit per stage.
module dapa_sqrt import dapa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  mags_t            in_mags,
  output logic             out_valid,
  output mags_t            out_mags,
  output logic [OPD_W-1:0] rho
);

  logic                sq_v;
  logic [2*Q8_W-1:0]   sqx, sqy;
  mags_t               sq_mags;

  logic                v_r    [SQ_BITS+1];
  logic [SQ_W-1:0]     n_r    [SQ_BITS+1];
  logic [SQ_W-1:0]     res_r  [SQ_BITS+1];
  mags_t               mags_r [SQ_BITS+1];

  // Square each planar magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (en) begin
      sq_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx     <= in_mags.mx * in_mags.mx;
      sqy     <= in_mags.my * in_mags.my;
      sq_mags <= in_mags;
    end
  end

  // Sum the squares into the radicand
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= SQ_W'(sqx) + SQ_W'(sqy);
      res_r[0]  <= '0;
      mags_r[0] <= sq_mags;
    end
  end

  // One digit of the root per stage, highest first
  for (genvar s = 0; s < SQ_BITS; s++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_BITS - 1 - s));
    logic [SQ_W-1:0] trial;

    assign trial = res_r[s] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mags_r[s+1] <= mags_r[s];
        if (n_r[s] >= trial) begin
          n_r[s+1]   <= n_r[s] - trial;
          res_r[s+1] <= (res_r[s] >> 1) + BIT;
        end else begin
          n_r[s+1]   <= n_r[s];
          res_r[s+1] <= res_r[s] >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[SQ_BITS];
  assign out_mags  = mags_r[SQ_BITS];
  assign rho       = res_r[SQ_BITS][OPD_W-1:0];

endmodule

@@ rtl/dapa_cordic.sv @@
// Pipelined CORDIC vectoring: first-quadrant angle of (xm, ym) in degrees Q16.
module dapa_cordic import dapa_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [OPD_W-1:0] xm,
  input  logic [OPD_W-1:0] ym,
  input  flags_t           in_fl,
  output logic             out_valid,
  output logic [ANG_W-1:0] angle,
  output flags_t           out_fl
);

  logic                   v_r   [STAGES+1];
  logic signed [CR_W-1:0] x_r   [STAGES+1];
  logic signed [CR_W-1:0] y_r   [STAGES+1];
  logic signed [Z_W-1:0]  z_r   [STAGES+1];
  logic                   xz_r  [STAGES+1];
  logic                   yz_r  [STAGES+1];
  flags_t                 fl_r  [STAGES+1];
  logic                   v_out;
  logic [ANG_W-1:0]       angle_next;

  // Load operands, note the on-axis cases
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= $signed({{(CR_W-OPD_W-PRESHIFT){1'b0}}, xm, {PRESHIFT{1'b0}}});
      y_r[0]  <= $signed({{(CR_W-OPD_W-PRESHIFT){1'b0}}, ym, {PRESHIFT{1'b0}}});
      z_r[0]  <= '0;
      xz_r[0] <= (xm == '0);
      yz_r[0] <= (ym == '0);
      fl_r[0] <= in_fl;
    end
  end

  // Rotate toward the x axis one micro-angle per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [CR_W-1:0] xs, ys;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xz_r[i+1] <= xz_r[i];
        yz_r[i+1] <= yz_r[i];
        fl_r[i+1] <= fl_r[i];
        if (!y_r[i][CR_W-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ATAN_Q16[i];
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ATAN_Q16[i];
        end
      end
    end
  end

  // Clamp to 0..90 degrees and apply the on-axis results
  always_comb begin
    priority if (yz_r[STAGES]) begin
      angle_next = '0;
    end else if (xz_r[STAGES]) begin
      angle_next = DEG90_A;
    end else if (z_r[STAGES][Z_W-1]) begin
      angle_next = '0;
    end else if (z_r[STAGES] > DEG90_Z) begin
      angle_next = DEG90_A;
    end else begin
      angle_next = z_r[STAGES][ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle  <= angle_next;
      out_fl <= fl_r[STAGES];
    end
  end

  assign out_valid = v_out;

endmodule

@@ rtl/dapa_skid.sv @@
// Output register with a skid entry; stalls the pipeline only when the skid fills.
module dapa_skid import dapa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  res_t      in_res,
  output logic      en,
  dapa_out_if.source dst
);

  logic o_valid, s_valid;
  res_t o_res, s_res;
  logic take, incoming;

  assign en       = !s_valid;
  assign take     = o_valid && dst.ready;
  assign incoming = in_valid && en;

  // Control: refill from skid first, then from the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (take) begin
      if (s_valid) begin
        s_valid <= 1'b0;
      end else begin
        o_valid <= incoming;
      end
    end else if (!o_valid) begin
      o_valid <= incoming;
    end else if (incoming) begin
      s_valid <= 1'b1;
    end
  end

  // Payload: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (take && s_valid) begin
      o_res <= s_res;
    end else if (take || !o_valid) begin
      o_res <= in_res;
    end
    if (!take && o_valid && incoming) begin
      s_res <= in_res;
    end
  end

  assign dst.valid       = o_valid;
  assign dst.azimuth_deg = o_res.azimuth_deg;
  assign dst.polar_deg   = o_res.polar_deg;
  assign dst.zero_length = o_res.zero_length;

endmodule

@@ rtl/direction_azimuth_polar_angle.sv @@
// Direction angles (azimuth, polar) of the vector from a start point to an end point.
// Usage:
//   points: sink channel, one transaction per start/end point pair (signed coordinates).
//   angles: source channel, one transaction per pair: azimuth_deg 0..360,
//           polar_deg 0..180 from +z, both rounded half up, and zero_length.
//   A transaction moves when valid and ready are both high at a clock edge.
// Throughput: one point pair per clock cycle, sustained while angles keeps ready high.
// Pipeline: 4 front stages, 2 + 26 square root stages, CORDIC_STAGES + 2 vectoring
//   stages, one fold stage and the output register. The 26-stage square root is the
//   longest part at the default CORDIC_STAGES.
// Reset (rst, synchronous): clears all valid bits; no clearing pass, points.ready
//   is high in the first cycle after reset.
// Stall: a result waiting on angles does not block points; the next result drops
//   into a skid entry, and only when that entry is occupied does the whole
//   pipeline freeze and points.ready go low. Nothing is lost or repeated.
module direction_azimuth_polar_angle import dapa_pkg::*; #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst,
  dapa_in_if.sink    points,
  dapa_out_if.source angles
);

  logic             en;
  logic             fr_valid;
  mags_t            fr_mags;
  logic             sq_valid;
  mags_t            sq_mags;
  logic [OPD_W-1:0] rho;
  logic             az_valid, po_valid;
  logic [ANG_W-1:0] az_angle, po_angle;
  flags_t           az_fl, po_fl;
  logic [AZ_W-1:0]  az_q, po_q, az_sum, po_sum;
  logic             fold_valid;
  res_t             fold_res;

  assign points.ready = en;

  dapa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (points.valid),
    .start_x   (points.start_x),
    .start_y   (points.start_y),
    .start_z   (points.start_z),
    .end_x     (points.end_x),
    .end_y     (points.end_y),
    .end_z     (points.end_z),
    .out_valid (fr_valid),
    .out_mags  (fr_mags)
  );

  dapa_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_mags   (fr_mags),
    .out_valid (sq_valid),
    .out_mags  (sq_mags),
    .rho       (rho)
  );

  // Azimuth: angle of (|dx|, |dy|)
  dapa_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .xm        (OPD_W'(sq_mags.mx)),
    .ym        (OPD_W'(sq_mags.my)),
    .in_fl     (sq_mags.fl),
    .out_valid (az_valid),
    .angle     (az_angle),
    .out_fl    (az_fl)
  );

  // Polar: angle of (|dz|, rho)
  dapa_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_po (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .xm        (OPD_W'(sq_mags.mz)),
    .ym        (rho),
    .in_fl     (sq_mags.fl),
    .out_valid (po_valid),
    .angle     (po_angle),
    .out_fl    (po_fl)
  );

  // Fold the first-quadrant angles back by sign, then round half up
  always_comb begin
    unique case ({az_fl.neg_x, az_fl.neg_y})
      2'b00:   az_q = AZ_W'(az_angle);
      2'b10:   az_q = DEG180_Q16 - AZ_W'(az_angle);
      2'b11:   az_q = DEG180_Q16 + AZ_W'(az_angle);
      default: az_q = DEG360_Q16 - AZ_W'(az_angle);
    endcase
    po_q   = po_fl.neg_z ? (DEG180_Q16 - AZ_W'(po_angle)) : AZ_W'(po_angle);
    az_sum = az_q + ROUND_HALF;
    po_sum = po_q + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (en) begin
      fold_valid <= az_valid && po_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (po_fl.zero) begin
        fold_res.azimuth_deg <= '0;
        fold_res.polar_deg   <= '0;
        fold_res.zero_length <= 1'b1;
      end else begin
        fold_res.azimuth_deg <= az_sum[FRAC_DEG +: AZ_DEG_W];
        fold_res.polar_deg   <= po_sum[FRAC_DEG +: PO_DEG_W];
        fold_res.zero_length <= 1'b0;
      end
    end
  end

  dapa_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fold_valid),
    .in_res   (fold_res),
    .en       (en),
    .dst      (angles)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for direction_azimuth_polar_angle: directed table, random point pairs, stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dapa_pkg::*;

  localparam int      COORD_W         = 16;
  localparam int      CORDIC_STAGES   = 16;
  localparam realtime CLK_PERIOD      = 20ns;
  localparam int      RESET_CYCLES    = 5;
  localparam int      RANDOM_ITEMS    = 1627;
  localparam int      MAX_REPORTS     = 10;
  localparam int      DRAIN_CYCLES    = 60;
  localparam int      WATCHDOG_LIMIT  = 5000;
  localparam int      PRESSURE_AT     = 300;
  localparam int      PRESSURE_CYCLES = 400;

  // Angle arithmetic: degrees in Q16
  localparam longint RIGHT_ANGLE_Q16 = 64'sd5898240;
  localparam longint HALF_TURN_Q16   = 64'sd11796480;
  localparam longint FULL_TURN_Q16   = 64'sd23592960;
  localparam longint HALF_DEG_Q16    = 64'sd32768;
  localparam longint MAG_CEIL        = 64'sd131072;
  localparam int     ATAN_STEPS      = 24;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam longint ATAN_DEG_Q16 [ATAN_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] CMAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] C0   = 16'sd0;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } point_pair_t;

  // given = 1: the angles in the row are the expected result
  typedef struct packed {
    point_pair_t pts;
    logic        given;
    res_t        want;
  } directed_row_t;

  localparam int DIRECTED_N = 23;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // zero-length vectors
    '{'{C0, C0, C0, C0, C0, C0}, 1'b1, '{9'd0, 8'd0, 1'b1}},
    '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, '{9'd0, 8'd0, 1'b1}},
    '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{9'd0, 8'd0, 1'b1}},
    // vectors along the axes
    '{'{C0, C0, C0, 16'sd100, C0, C0}, 1'b1, '{9'd0, 8'd90, 1'b0}},
    '{'{C0, C0, C0, C0, 16'sd100, C0}, 1'b1, '{9'd90, 8'd90, 1'b0}},
    '{'{C0, C0, C0, -16'sd100, C0, C0}, 1'b1, '{9'd180, 8'd90, 1'b0}},
    '{'{C0, C0, C0, C0, -16'sd100, C0}, 1'b1, '{9'd270, 8'd90, 1'b0}},
    '{'{C0, C0, C0, C0, C0, 16'sd100}, 1'b1, '{9'd0, 8'd0, 1'b0}},
    '{'{C0, C0, C0, C0, C0, -16'sd100}, 1'b1, '{9'd0, 8'd180, 1'b0}},
    // tiny negative dy rounds up to a full turn
    '{'{C0, C0, C0, CMAX, -16'sd1, C0}, 1'b1, '{9'd360, 8'd90, 1'b0}},
    // full-span differences
    '{'{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, 1'b0, '0},
    '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b0, '0},
    '{'{CMAX, CMIN, C0, CMIN, CMAX, C0}, 1'b0, '0},
    // oblique vectors in all four quadrants, plus two short ones
    '{'{C0, C0, C0, 16'sd1000, 16'sd1000, 16'sd500}, 1'b0, '0},
    '{'{C0, C0, C0, -16'sd1000, 16'sd1000, -16'sd500}, 1'b0, '0},
    '{'{C0, C0, C0, -16'sd1000, -16'sd1000, 16'sd500}, 1'b0, '0},
    '{'{C0, C0, C0, 16'sd1000, -16'sd1000, -16'sd500}, 1'b0, '0},
    '{'{C0, C0, C0, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
    '{'{16'sd5, -16'sd7, 16'sd3, -16'sd5, 16'sd7, -16'sd3}, 1'b0, '0},
    // axis vectors at full span, and a short one in the x-z plane
    '{'{CMIN, C0, C0, CMAX, C0, C0}, 1'b1, '{9'd0, 8'd90, 1'b0}},
    '{'{C0, C0, CMAX, C0, C0, CMIN}, 1'b1, '{9'd0, 8'd180, 1'b0}},
    '{'{C0, C0, C0, -16'sd1, C0, 16'sd1}, 1'b0, '0},
    '{'{C0, CMAX, C0, C0, CMIN, C0}, 1'b1, '{9'd270, 8'd90, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  dapa_in_if #(.W(COORD_W)) points ();
  dapa_out_if               angles ();

  direction_azimuth_polar_angle #(
    .COORD_WIDTH  (COORD_W),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .points(points),
    .angles(angles)
  );

  res_t expected_angles [$];
  int   mismatches  = 0;
  int   idle_cycles = 0;
  bit   tx_burst    = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // First-quadrant angle of (xm, ym) by CORDIC vectoring, degrees Q16
  function automatic longint quadrant_angle(longint xm, longint ym);
    longint x, y, z, xs, ys;
    z = 0;
    if (ym == 0) return 0;
    if (xm == 0) return RIGHT_ANGLE_Q16;
    x = xm <<< 20;
    y = ym <<< 20;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > RIGHT_ANGLE_Q16) z = RIGHT_ANGLE_Q16;
    return z;
  endfunction

  // Floor of the square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Azimuth and polar angle of end minus start
  function automatic res_t direction_angles(point_pair_t p);
    longint dx, dy, dz, mx, my, mz, mmax, rho, a, b, az, po;
    res_t r;
    r = '0;
    dx = longint'(p.end_x) - longint'(p.start_x);
    dy = longint'(p.end_y) - longint'(p.start_y);
    dz = longint'(p.end_z) - longint'(p.start_z);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mz = (dz < 0) ? -dz : dz;
    if (mx == 0 && my == 0 && mz == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    // scale all magnitudes alike until the largest fits, then go to Q8
    mmax = (mx > my) ? mx : my;
    if (mz > mmax) mmax = mz;
    while (mmax >= MAG_CEIL) begin
      mmax = mmax >>> 1;
      mx = mx >>> 1;
      my = my >>> 1;
      mz = mz >>> 1;
    end
    mx = mx <<< 8;
    my = my <<< 8;
    mz = mz <<< 8;

    // unfold the azimuth from the first quadrant
    a = quadrant_angle(mx, my);
    if (dx >= 0 && dy >= 0)
      az = a;
    else if (dx < 0 && dy >= 0)
      az = HALF_TURN_Q16 - a;
    else if (dx < 0)
      az = HALF_TURN_Q16 + a;
    else
      az = FULL_TURN_Q16 - a;

    // polar angle from +z, folded on the sign of dz
    rho = longint'(int_sqrt(longint'(mx * mx + my * my)));
    b = quadrant_angle(mz, rho);
    po = (dz >= 0) ? b : HALF_TURN_Q16 - b;

    r.azimuth_deg = AZ_DEG_W'((az + HALF_DEG_Q16) >>> 16);
    r.polar_deg   = PO_DEG_W'((po + HALF_DEG_Q16) >>> 16);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return C0;
    endcase
  endfunction

  // Random point pair, mostly full range, with shaped vectors mixed in
  function automatic point_pair_t draw_points();
    point_pair_t p;
    int kind, axis, m;
    kind = $urandom_range(0, 19);
    p.start_x = COORD_W'($urandom);
    p.start_y = COORD_W'($urandom);
    p.start_z = COORD_W'($urandom);
    p.end_x   = COORD_W'($urandom);
    p.end_y   = COORD_W'($urandom);
    p.end_z   = COORD_W'($urandom);
    if (kind < 8) begin
      // keep full-range coordinates
    end else if (kind < 11) begin
      // short vectors: end within a few units of start
      p.start_x = COORD_W'(int'($urandom_range(0, 64000)) - 32000);
      p.start_y = COORD_W'(int'($urandom_range(0, 64000)) - 32000);
      p.start_z = COORD_W'(int'($urandom_range(0, 64000)) - 32000);
      p.end_x   = COORD_W'(int'(p.start_x) + int'($urandom_range(0, 16)) - 8);
      p.end_y   = COORD_W'(int'(p.start_y) + int'($urandom_range(0, 16)) - 8);
      p.end_z   = COORD_W'(int'(p.start_z) + int'($urandom_range(0, 16)) - 8);
    end else if (kind < 13) begin
      // along one axis
      axis = $urandom_range(0, 2);
      if (axis != 0) p.end_x = p.start_x;
      if (axis != 1) p.end_y = p.start_y;
      if (axis != 2) p.end_z = p.start_z;
    end else if (kind < 15) begin
      // in a coordinate plane
      axis = $urandom_range(0, 2);
      case (axis)
        0:       p.end_x = p.start_x;
        1:       p.end_y = p.start_y;
        default: p.end_z = p.start_z;
      endcase
    end else if (kind < 17) begin
      // |dx| equal to |dy|
      p.start_x = COORD_W'(int'($urandom_range(0, 32000)) - 16000);
      p.start_y = COORD_W'(int'($urandom_range(0, 32000)) - 16000);
      m = $urandom_range(1, 16000);
      p.end_x = COORD_W'(int'(p.start_x) + ($urandom_range(0, 1) ? m : -m));
      p.end_y = COORD_W'(int'(p.start_y) + ($urandom_range(0, 1) ? m : -m));
    end else if (kind < 18) begin
      // zero length
      p.end_x = p.start_x;
      p.end_y = p.start_y;
      p.end_z = p.start_z;
    end else begin
      p.start_x = corner_coord();
      p.start_y = corner_coord();
      p.start_z = corner_coord();
      p.end_x   = corner_coord();
      p.end_y   = corner_coord();
      p.end_z   = corner_coord();
    end
    return p;
  endfunction

  // Offer one point pair after a random gap; record its angles on acceptance
  task automatic send_points(input point_pair_t p, input res_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid   <= 1'b1;
    points.start_x <= p.start_x;
    points.start_y <= p.start_y;
    points.start_z <= p.start_z;
    points.end_x   <= p.end_x;
    points.end_y   <= p.end_y;
    points.end_z   <= p.end_z;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    expected_angles.push_back(want);
  endtask

  // Stimulus: reset, directed table, random pairs, then drain
  initial begin
    point_pair_t p;
    res_t        want;
    points.valid   <= 1'b0;
    points.start_x <= '0;
    points.start_y <= '0;
    points.start_z <= '0;
    points.end_x   <= '0;
    points.end_y   <= '0;
    points.end_z   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIRECTED_N; n++) begin
      p = DIRECTED_ROWS[n].pts;
      want = DIRECTED_ROWS[n].given ? DIRECTED_ROWS[n].want : direction_angles(p);
      send_points(p, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      p = draw_points();
      send_points(p, direction_angles(p));
    end
    points.valid <= 1'b0;

    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls per transaction, one long hold-off to back up the pipeline
  initial begin
    int stall, taken;
    bit rx_burst, held;
    taken = 0;
    rx_burst = 1'b0;
    held = 1'b0;
    angles.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (!held && taken == PRESSURE_AT) begin
        held = 1'b1;
        angles.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        angles.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      angles.ready <= 1'b1;
      @(posedge clk);
      while (!angles.valid) @(posedge clk);
      taken++;
    end
  end

  // Compare each angles transaction with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && angles.valid && angles.ready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected angles: az %0d po %0d zero %0b",
                   angles.azimuth_deg, angles.polar_deg, angles.zero_length);
      end else begin
        want = expected_angles.pop_front();
        if (angles.azimuth_deg !== want.azimuth_deg ||
            angles.polar_deg   !== want.polar_deg ||
            angles.zero_length !== want.zero_length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("angles mismatch at %t: expected az %0d po %0d zero %0b, got az %0d po %0d zero %0b",
                     $realtime, want.azimuth_deg, want.polar_deg, want.zero_length,
                     angles.azimuth_deg, angles.polar_deg, angles.zero_length);
        end
      end
    end
  end

  // Drop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (points.valid && points.ready) || (angles.valid && angles.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
rtl/dapa_pkg.sv
rtl/dapa_if.sv
rtl/dapa_front.sv
rtl/dapa_sqrt.sv
rtl/dapa_cordic.sv
rtl/dapa_skid.sv
rtl/direction_azimuth_polar_angle.sv
tb/tb.sv
